### rtl/core/dsm_pkg.sv
// ----------------------------------------------------------------------------
// dsm_pkg: shared types and codes for the dense slot map
// Beat payloads, response codes, register map and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package dsm_pkg;

  localparam int KIND_W      = 1;
  localparam int ENTITY_W    = 10;
  localparam int STATUS_W    = 2;
  localparam int SLOT_W      = 8;
  localparam int LIMIT_W     = 9;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [KIND_W-1:0] KIND_BIND   = 1'b0;
  localparam logic [KIND_W-1:0] KIND_UNBIND = 1'b1;

  localparam logic [STATUS_W-1:0] RSP_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] RSP_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] RSP_NOT_BOUND = 2'd2;

  // Register word index (byte address / 4)
  localparam logic REG_SLOT_LIMIT = 1'b0;

  localparam logic [LIMIT_W-1:0] SLOT_LIMIT_RESET = 9'd256;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ENTITY_W-1:0] entity_id;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                move_needed;
    logic [ENTITY_W-1:0] moved_entity;
    logic [SLOT_W-1:0]   moved_from_slot;
  } rsp_t;

  // Controller -> datapath
  typedef struct packed {
    logic capture;    // latch request, issue both map reads
    logic clr_en;     // clear the indexed entry of each map in range
    logic bind_wr;    // append entity at the tail slot
    logic move_wr;    // move tail entity into the freed slot
    logic retire_wr;  // invalidate tail slot and unbound entity
    logic emit;       // load the response register
  } dsm_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_unbind;
    logic bind_ok;
    logic unbind_ok;
    logic out_free;
    logic clr_last;
  } dsm_sts_t;

endpackage

### rtl/core/dsm_ctrl.sv
// ----------------------------------------------------------------------------
// dsm_ctrl: request sequencer
// Runs the clearing pass, then steps each request through read, evaluate
// and (for a successful unbind) a second write pass.
// ----------------------------------------------------------------------------
module dsm_ctrl
  import dsm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  dsm_sts_t sts,
  output dsm_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_RETIRE
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_stall  = 1'b1;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.is_unbind && sts.unbind_ok) begin
          cmd.move_wr = 1'b1;
          state_next  = S_RETIRE;
        end else if (sts.out_free) begin
          cmd.bind_wr = !sts.is_unbind && sts.bind_ok;
          cmd.emit    = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_RETIRE: begin
        if (sts.out_free) begin
          cmd.retire_wr = 1'b1;
          cmd.emit      = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/dsm_datapath.sv
// ----------------------------------------------------------------------------
// dsm_datapath: forward and reverse maps, occupancy count, response register
// Holds both map memories with registered reads and builds the response.
// ----------------------------------------------------------------------------
module dsm_datapath
  import dsm_pkg::*;
#(
  parameter int SLOT_COUNT   = 256,
  parameter int ENTITY_COUNT = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  req_t               req,
  input  logic [LIMIT_W-1:0] slot_limit,
  input  dsm_cmd_t           cmd,
  output dsm_sts_t           sts,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsp_t               rsp
);

  localparam int SW        = $clog2(SLOT_COUNT);
  localparam int CW        = $clog2(SLOT_COUNT + 1);
  localparam int EW        = $clog2(ENTITY_COUNT);
  localparam int LW        = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int XW        = ((EW > ENTITY_W) ? EW : ENTITY_W) + 1;
  localparam int CLR_DEPTH = (ENTITY_COUNT > SLOT_COUNT) ? ENTITY_COUNT : SLOT_COUNT;
  localparam int CLW       = $clog2(CLR_DEPTH);

  // Map words: top bit is the valid flag
  logic [SW:0] e2s_mem [ENTITY_COUNT];
  logic [EW:0] s2e_mem [SLOT_COUNT];

  logic [SW:0]          e2s_rd;
  logic [EW:0]          s2e_rd;
  logic [KIND_W-1:0]    kind;
  logic [ENTITY_W-1:0]  ent;
  logic [CW-1:0]        count;
  logic [CLW-1:0]       clr_idx;

  logic                 e2s_we;
  logic [EW-1:0]        e2s_wa;
  logic [SW:0]          e2s_wd;
  logic                 s2e_we;
  logic [SW-1:0]        s2e_wa;
  logic [EW:0]          s2e_wd;

  logic [LW-1:0]        limit;
  logic                 full;
  logic                 ent_ok;
  logic [EW-1:0]        ent_idx;
  logic [SW-1:0]        dead;
  logic [SW-1:0]        last;
  logic [SW-1:0]        tail_addr;
  logic                 last_ok;
  logic [EW-1:0]        mover;
  logic                 moved;
  rsp_t                 rsp_next;
  logic                 out_free;

  // Capture request and read both maps at the accept edge
  assign tail_addr = SW'(count - CW'(1));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind <= req.kind;
      ent  <= req.entity_id;
    end
  end

  always_ff @(posedge clk) begin
    if (e2s_we) begin
      e2s_mem[e2s_wa] <= e2s_wd;
    end
    if (cmd.capture) begin
      e2s_rd <= e2s_mem[EW'(req.entity_id)];
    end
  end

  always_ff @(posedge clk) begin
    if (s2e_we) begin
      s2e_mem[s2e_wa] <= s2e_wd;
    end
    if (cmd.capture) begin
      s2e_rd <= s2e_mem[tail_addr];
    end
  end

  // Request evaluation
  assign limit   = (LW'(slot_limit) > LW'(SLOT_COUNT)) ? LW'(SLOT_COUNT) : LW'(slot_limit);
  assign full    = LW'(count) >= limit;
  assign ent_ok  = XW'(ent) < XW'(ENTITY_COUNT);
  assign ent_idx = EW'(ent);
  assign dead    = e2s_rd[SW-1:0];
  assign last    = tail_addr;
  assign last_ok = s2e_rd[EW];
  assign mover   = s2e_rd[EW-1:0];
  assign moved   = dead != last;

  assign sts.is_unbind = kind == KIND_UNBIND;
  assign sts.bind_ok   = ent_ok && !full;
  assign sts.unbind_ok = ent_ok && e2s_rd[SW] && (CW'(dead) < count);
  assign sts.out_free  = out_free;
  assign sts.clr_last  = clr_idx == CLW'(CLR_DEPTH - 1);

  // Map write port selection
  always_comb begin
    e2s_we = 1'b0;
    e2s_wa = '0;
    e2s_wd = '0;
    s2e_we = 1'b0;
    s2e_wa = '0;
    s2e_wd = '0;
    if (cmd.clr_en) begin
      e2s_we = (CLW + 1)'(clr_idx) < (CLW + 1)'(ENTITY_COUNT);
      e2s_wa = EW'(clr_idx);
      s2e_we = (CLW + 1)'(clr_idx) < (CLW + 1)'(SLOT_COUNT);
      s2e_wa = SW'(clr_idx);
    end else if (cmd.bind_wr) begin
      e2s_we = 1'b1;
      e2s_wa = ent_idx;
      e2s_wd = {1'b1, SW'(count)};
      s2e_we = 1'b1;
      s2e_wa = SW'(count);
      s2e_wd = {1'b1, ent_idx};
    end else if (cmd.move_wr) begin
      e2s_we = last_ok;
      e2s_wa = mover;
      e2s_wd = {1'b1, dead};
      s2e_we = 1'b1;
      s2e_wa = dead;
      s2e_wd = {last_ok, mover};
    end else if (cmd.retire_wr) begin
      e2s_we = 1'b1;
      e2s_wa = ent_idx;
      s2e_we = 1'b1;
      s2e_wa = last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      clr_idx <= '0;
    end else begin
      if (cmd.clr_en) begin
        clr_idx <= clr_idx + CLW'(1);
      end
      if (cmd.bind_wr) begin
        count <= count + CW'(1);
      end else if (cmd.retire_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  // Response build
  always_comb begin
    rsp_next = '0;
    if (!ent_ok) begin
      rsp_next.status = RSP_NOT_BOUND;
    end else if (kind == KIND_BIND) begin
      if (full) begin
        rsp_next.status = RSP_FULL;
      end else begin
        rsp_next.status = RSP_DONE;
        rsp_next.slot   = SLOT_W'(count);
      end
    end else if (!sts.unbind_ok) begin
      rsp_next.status = RSP_NOT_BOUND;
    end else begin
      rsp_next.status      = RSP_DONE;
      rsp_next.slot        = SLOT_W'(dead);
      rsp_next.move_needed = moved;
      if (moved) begin
        rsp_next.moved_entity    = last_ok ? ENTITY_W'(mover) : '0;
        rsp_next.moved_from_slot = SLOT_W'(last);
      end
    end
  end

  assign out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp <= rsp_next;
    end
  end

endmodule

### rtl/core/dense_slot_map_swap_remove_core.sv
// ----------------------------------------------------------------------------
// dense_slot_map_swap_remove_core: dense slot map with swap-remove
// Sequence: a bind or failed request passes accept and evaluate before its
//   response beat is registered; a successful unbind adds a retire step
//   (second write pass on both maps). A request is taken only once the last
//   is finished, set by the single write port of each map and registered reads.
// Reset: clears count and response valid, then a clearing pass over
//   max(ENTITY_COUNT, SLOT_COUNT) entries invalidates both maps; requests stall.
// ----------------------------------------------------------------------------
module dense_slot_map_swap_remove_core
  import dsm_pkg::*;
#(
  parameter int SLOT_COUNT   = 256,
  parameter int ENTITY_COUNT = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req,
  // response channel
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [LIMIT_W-1:0] slot_limit;
  logic               reg_idx;
  dsm_cmd_t           cmd;
  dsm_sts_t           sts;

  // Register file: one word, addressed by word index paddr[2]
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_limit <= SLOT_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_SLOT_LIMIT: slot_limit <= pwdata[LIMIT_W-1:0];
        default: ;  // writes past the map are dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SLOT_LIMIT: prdata = APB_DATA_W'(slot_limit);
      default:        prdata = '0;
    endcase
  end

  // Sequencer: clearing pass, accept, evaluate, optional second write pass.
  // The request side is open only when idle; the response register lets a
  // finished beat wait while the next request is taken and read.
  dsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Maps, count and response register. An unbind moves the tail entry into
  // the freed slot in the first write pass and invalidates the tail slot and
  // the unbound entity in the second; the count drops with the second pass.
  dsm_datapath #(
    .SLOT_COUNT   (SLOT_COUNT),
    .ENTITY_COUNT (ENTITY_COUNT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .slot_limit (slot_limit),
    .cmd        (cmd),
    .sts        (sts),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for dense_slot_map_swap_remove_core
// Drives bind and unbind beats with bursty valid, stalls the response side
// on a changing pattern and checks every response beat against a
// swap-remove slot map predictor. The slot limit is reprogrammed between
// traffic phases, and only while the block is idle.
// ----------------------------------------------------------------------------
module testbench
  import dsm_pkg::*;
();

  localparam int SLOTS        = 256;
  localparam int ENTITIES     = 1024;
  localparam int CYCLE_LIMIT  = 400000;
  // Wait after the last response beat so that the final map write pass has finished.
  localparam int SETTLE_CYCLES = 4;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors both maps and the count, and queues one expected
  // response per accepted request beat.
  // --------------------------------------------------------------------------
  class slot_map_scoreboard;
    bit                  ent_bound [ENTITIES];
    logic [SLOT_W-1:0]   ent_slot  [ENTITIES];
    bit                  slot_used [SLOTS];
    logic [ENTITY_W-1:0] slot_ent  [SLOTS];
    int unsigned         count;
    int unsigned         limit;
    rsp_t                expected_q[$];
    int                  errors;
    int                  beats_seen;

    function new();
      foreach (ent_bound[i]) begin
        ent_bound[i] = 1'b0;
        ent_slot[i]  = '0;
      end
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_ent[i]  = '0;
      end
      count      = 0;
      limit      = SLOT_LIMIT_RESET;
      errors     = 0;
      beats_seen = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] value);
      limit = value;
    endfunction

    // Apply one accepted request to the mirrored maps and queue its response.
    function void note_request(req_t r);
      rsp_t                want;
      int unsigned         eff_limit;
      int unsigned         dead;
      int unsigned         last;
      bit                  last_ok;
      logic [ENTITY_W-1:0] mover;
      want      = '0;
      eff_limit = (limit > SLOTS) ? SLOTS : limit;
      if (r.kind == KIND_BIND) begin
        if (count >= eff_limit) begin
          want.status = RSP_FULL;
        end else begin
          // Rebind overwrites the forward entry; the old reverse entry stays.
          slot_ent[count]         = r.entity_id;
          slot_used[count]        = 1'b1;
          ent_slot[r.entity_id]   = SLOT_W'(count);
          ent_bound[r.entity_id]  = 1'b1;
          want.status             = RSP_DONE;
          want.slot               = SLOT_W'(count);
          count++;
        end
      end else if (!ent_bound[r.entity_id] || count == 0 ||
                   ent_slot[r.entity_id] >= count) begin
        want.status = RSP_NOT_BOUND;
      end else begin
        dead    = ent_slot[r.entity_id];
        last    = count - 1;
        last_ok = slot_used[last];
        mover   = slot_ent[last];
        slot_ent[dead]  = mover;
        slot_used[dead] = last_ok;
        if (last_ok) begin
          ent_slot[mover]  = SLOT_W'(dead);
          ent_bound[mover] = 1'b1;
        end
        slot_used[last]        = 1'b0;
        slot_ent[last]         = '0;
        ent_bound[r.entity_id] = 1'b0;
        ent_slot[r.entity_id]  = '0;
        count--;
        want.status = RSP_DONE;
        want.slot   = SLOT_W'(dead);
        if (dead != last) begin
          want.move_needed     = 1'b1;
          want.moved_entity    = last_ok ? mover : '0;
          want.moved_from_slot = SLOT_W'(last);
        end
      end
      expected_q.push_back(want);
    endfunction

    task report(string msg);
      $display("MISMATCH response %0d: %s", beats_seen, msg);
      errors++;
    endtask

    task check_field(string name, int got, int want);
      if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_response(rsp_t got);
      rsp_t want;
      if ($isunknown(got)) begin
        report($sformatf("unknown bits in response %h", got));
      end
      if (expected_q.size() == 0) begin
        report($sformatf("response %h with nothing outstanding", got));
      end else begin
        want = expected_q.pop_front();
        check_field("status",          got.status,          want.status);
        check_field("slot",            got.slot,            want.slot);
        check_field("move_needed",     got.move_needed,     want.move_needed);
        check_field("moved_entity",    got.moved_entity,    want.moved_entity);
        check_field("moved_from_slot", got.moved_from_slot, want.moved_from_slot);
      end
      beats_seen++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block under test
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst;
  logic                  req_valid;
  logic                  req_stall;
  req_t                  req;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  rsp_t                  rsp;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  slot_map_scoreboard sb = new();

  int  cycles     = 0;
  int  burst_left = 0;
  bit  req_up     = 1'b0;  // mirrors req_valid without waiting on the NBA
  int  stall_mode = 0;
  int  stall_left = 0;

  always #6 clk = ~clk;

  dense_slot_map_swap_remove_core DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Bound the run: a hang anywhere ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Response stall: switch between stretches of no stall, light and heavy
  // random stall, and a toggling pattern, so gaps land on every phase.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(3);
      stall_left = $urandom_range(200, 20);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_mode)
      0: begin
        rsp_stall <= 1'b0;
      end
      1: begin
        rsp_stall <= ($urandom_range(99) < 25);
      end
      2: begin
        rsp_stall <= ($urandom_range(99) < 70);
      end
      default: begin
        rsp_stall <= ~rsp_stall;
      end
    endcase
  end

  // Response monitor: a beat moves when valid is high and stall is low.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      sb.check_response(rsp);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Present one request beat and hold it until accepted. Between most bursts,
  // drop valid for a random gap.
  task automatic send_request(logic [KIND_W-1:0] kind, logic [ENTITY_W-1:0] id);
    req_t r;
    r.kind      = kind;
    r.entity_id = id;
    req       <= r;
    req_valid <= 1'b1;
    req_up     = 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(r);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12);
      if ($urandom_range(3) != 0) begin
        req_valid <= 1'b0;
        req_up     = 1'b0;
        repeat ($urandom_range(($urandom_range(7) == 0) ? 30 : 6, 1)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Stop sending and hold off until every response beat is back, then let
  // the last write pass of the maps finish.
  task automatic drain_responses();
    if (req_up) begin
      req_valid <= 1'b0;
      req_up     = 1'b0;
    end
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of the slot limit: setup cycle, then access cycle. Upper data
  // bits are random and must be ignored. Read the register back after.
  task automatic write_slot_limit(logic [LIMIT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({REG_SLOT_LIMIT, 2'b00});
    pwdata  <= {23'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_limit(value);
    // Read back: setup, then sample prdata at the access edge.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[LIMIT_W-1:0] !== value || prdata[APB_DATA_W-1:LIMIT_W] != '0) begin
      sb.report($sformatf("slot limit read %0d expected %0d", prdata, value));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Pick an entity: a live_pct share of ones that sit in a slot (so unbinds and
  // rebinds hit live entries), some from a small pool to force collisions,
  // and the rest anywhere in the id space.
  function automatic logic [ENTITY_W-1:0] pick_entity(int live_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < live_pct && sb.count > 0) begin
      return sb.slot_ent[$urandom_range(sb.count - 1)];
    end else if (roll < live_pct + 15) begin
      return ENTITY_W'($urandom_range(15));
    end
    return ENTITY_W'($urandom_range(ENTITIES - 1));
  endfunction

  // A phase of random traffic with a given share of binds.
  task automatic random_traffic(int items, int bind_pct);
    logic [KIND_W-1:0] kind;
    for (int i = 0; i < items; i++) begin
      kind = ($urandom_range(99) < bind_pct) ? KIND_BIND : KIND_UNBIND;
      send_request(kind, pick_entity((kind == KIND_BIND) ? 8 : 75));
      // Now and then pause until the block has nothing in flight.
      if ($urandom_range(99) == 0) drain_responses();
    end
  endtask

  task automatic traffic_phase(logic [LIMIT_W-1:0] limit_value, int items, int bind_pct);
    drain_responses();
    write_slot_limit(limit_value);
    random_traffic(items, bind_pct);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset limit, empty table, id extremes, moves, no-move
    // unbinds, unbinds of unknown ids, and a rebind that leaves a stale
    // reverse entry which later gets moved.
    send_request(KIND_UNBIND, 10'd7);     // empty table
    send_request(KIND_BIND,   10'd0);
    send_request(KIND_BIND,   10'd1023);
    send_request(KIND_BIND,   10'h155);
    send_request(KIND_BIND,   10'h2AA);
    send_request(KIND_UNBIND, 10'd1023);  // middle slot, tail moves in
    send_request(KIND_UNBIND, 10'd0);     // first slot, tail moves in
    send_request(KIND_UNBIND, 10'h2AA);   // already the tail, no move
    send_request(KIND_UNBIND, 10'd0);     // no longer bound
    send_request(KIND_UNBIND, 10'd1023);
    send_request(KIND_BIND,   10'd5);
    send_request(KIND_BIND,   10'd5);     // rebind, old slot keeps its entry
    send_request(KIND_BIND,   10'd9);
    send_request(KIND_UNBIND, 10'd5);
    send_request(KIND_UNBIND, 10'h155);
    send_request(KIND_UNBIND, 10'd9);     // tail holds the stale rebind entry
    send_request(KIND_UNBIND, 10'd5);
    send_request(KIND_UNBIND, 10'd5);

    // Limit above the slot count acts as full size: fill the table and
    // keep binding into full reports.
    traffic_phase(9'd511, 400, 90);
    // Lower the limit below the count: binds fail, unbinds keep working.
    traffic_phase(9'd3,   120, 40);
    // Zero limit: every bind is full.
    traffic_phase(9'd0,   50,  50);
    // Drain the table back toward empty.
    traffic_phase(9'd256, 250, 10);
    // Tiny tables churn through full, no-move and empty cases.
    traffic_phase(9'd1,   80,  50);
    traffic_phase(9'd2,   80,  50);
    traffic_phase(9'd256, 450, 55);
    for (int p = 0; p < 4; p++) begin
      traffic_phase(LIMIT_W'($urandom_range(300, 1)), 50, 60);
    end

    drain_responses();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
